// File: rtl/tgbm_pkg.sv
// ----------------------------------------------------------------------------
// tgbm_pkg
// Shared constants, hash constants and state type of the two-generation
// Bloom matcher.
// ----------------------------------------------------------------------------
package tgbm_pkg;

    // Filter geometry; ROW_BITS must be a power of two of at least 64.
    localparam int NUM_HASHES = 4;
    localparam int ROW_BITS   = 4096;
    localparam int ROW_W      = $clog2(ROW_BITS);
    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WPR_W      = ROW_W - BIT_W;
    localparam int FILT_WORDS = NUM_HASHES * ROW_BITS / WORD_BITS;
    localparam int MEM_DEPTH  = 2 * FILT_WORDS;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int ROW_IW     = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;

    // MurmurHash64A constants.
    localparam logic [63:0] MM_MUL     = 64'hc6a4a7935bd1e995;
    localparam logic [63:0] MM_M16     = MM_MUL << 4;
    localparam logic [63:0] FIRST_SEED = 64'h0000_0000_9747_b28c;
    localparam int          MM_SHIFT   = 47;

    // Item modes.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIV,
        ST_ROT,
        ST_WIPE,
        ST_HASH,
        ST_RD,
        ST_USE
    } t_state;

endpackage

// File: rtl/tgbm_ram.sv
// ----------------------------------------------------------------------------
// tgbm_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module tgbm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/two_generation_bloom_matcher_top.sv
// ----------------------------------------------------------------------------
// two_generation_bloom_matcher_top
// Request/response matcher built on two rotating Bloom filters.
// ----------------------------------------------------------------------------
// Each item is a request (insert) or a response (query) and yields one result
// item carrying the hit flag. Items are handled one at a time. An item first
// computes a bit-serial remainder of the timestamp by the rotation interval; a
// rotation then wipes the newly active filter, one 64-bit memory word a cycle,
// NUM_HASHES*ROW_BITS/64 words (256 by default). The two chained MurmurHash64A
// hashes share one 32x32 multiplier, three partial products per 64-bit
// product, ten products in all. Probes use the single memory port, each a
// read (ST_RD) then a use (ST_USE): NUM_HASHES for an insert, twice that for a
// query. After reset a clearing pass zeroes both filters (2*NUM_HASHES*ROW_BITS/64
// words, 512 by default) before the first item is taken; configuration writes
// are accepted throughout.
// ----------------------------------------------------------------------------
module two_generation_bloom_matcher_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration: rotation interval in seconds
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata,
    // Input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // time_sec, src_addr, dst_addr, src_port, dst_port, txn_id (from bit 0)
    input  logic [143:0] s_axis_tdata,
    // mode
    input  logic [0:0]   s_axis_tuser,
    // Result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit, then zero fill
    output logic [7:0]   m_axis_tdata
);

    import tgbm_pkg::*;

    t_state r_state, n_state;

    logic [7:0]         r_ivl;
    logic               r_mode;
    logic [31:0]        r_time;
    logic [31:0]        r_last;
    logic               r_act;
    logic [63:0]        r_w0, r_w1;
    logic [4:0]         r_cnt;
    logic [7:0]         r_rem;
    logic [63:0]        r_x, r_acc, r_m0, r_m1, r_a;
    logic [ROW_W-1:0]   r_b;
    logic [1:0]         r_mc;
    logic [2:0]         r_ph;
    logic               r_pass;
    logic [ROW_IW-1:0]  r_row;
    logic               r_pf;
    logic [ROW_W-1:0]   r_n;
    logic               r_h0, r_h1;
    logic [MEM_AW-1:0]  r_clr_addr;
    logic [MEM_AW:0]    r_clr_left;
    logic               r_ovalid;
    logic               r_ohit;

    // Memory interface.
    logic                  ram_we;
    logic [MEM_AW-1:0]     ram_waddr, ram_raddr, probe_addr;
    logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;

    tgbm_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Remainder step of the bit-serial modulo.
    logic [8:0] rem_sh;
    logic [7:0] rem_nx;
    always_comb begin
        rem_sh = {r_rem, r_time[~r_cnt]};
        if (rem_sh >= {1'b0, r_ivl}) begin
            rem_nx = 8'(rem_sh - {1'b0, r_ivl});
        end else begin
            rem_nx = rem_sh[7:0];
        end
    end

    // Shared multiplier: one 32x32 partial product of r_x * MM_MUL a cycle.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p, full, fin;
    always_comb begin
        mul_a = (r_mc == 2'd1) ? r_x[63:32] : r_x[31:0];
        mul_b = (r_mc == 2'd2) ? MM_MUL[63:32] : MM_MUL[31:0];
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
        if (r_mc == 2'd0) begin
            full = mul_p;
        end else begin
            full = {r_acc[63:32] + mul_p[31:0], r_acc[31:0]};
        end
        fin = full ^ (full >> MM_SHIFT);
    end

    // Probe position and word address.
    logic             probe_f;
    logic             probe_bit;
    logic             last_probe;
    logic [WORD_BITS-1:0] bit_mask;
    always_comb begin
        probe_f    = (r_mode == MODE_QUERY) ? r_pf : r_act;
        probe_addr = (probe_f ? MEM_AW'(FILT_WORDS) : '0)
                   + (MEM_AW'(r_row) << WPR_W)
                   + MEM_AW'(r_n >> BIT_W);
        probe_bit  = ram_rdata[r_n[BIT_W-1:0]];
        bit_mask   = WORD_BITS'(1) << r_n[BIT_W-1:0];
        last_probe = (r_row == ROW_IW'(NUM_HASHES - 1))
                   && ((r_mode == MODE_INSERT) || r_pf);
    end

    logic rot_now;
    assign rot_now = (r_rem == 8'd0) && (r_time != r_last);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (r_clr_left == (MEM_AW + 1)'(1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == 5'd31) n_state = ST_ROT;
            end
            ST_ROT: begin
                n_state = rot_now ? ST_WIPE : ST_HASH;
            end
            ST_WIPE: begin
                if (r_clr_left == (MEM_AW + 1)'(1)) n_state = ST_HASH;
            end
            ST_HASH: begin
                if (r_mc == 2'd2 && r_ph == 3'd6 && r_pass) n_state = ST_RD;
            end
            ST_RD: begin
                n_state = ST_USE;
            end
            ST_USE: begin
                if (!last_probe) begin
                    n_state = ST_RD;
                end else if (!r_ovalid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    // Outputs and memory control.
    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = probe_addr;
        ram_wdata     = ram_rdata | bit_mask;
        ram_raddr     = probe_addr;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_INIT, ST_WIPE: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            ST_USE: begin
                ram_we = (r_mode == MODE_INSERT);
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_ohit};

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ivl <= 8'd1;
        end else if (i_cfg_we) begin
            r_ivl <= (i_cfg_wdata == 8'd0) ? 8'd1 : i_cfg_wdata;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_last     <= '0;
            r_act      <= 1'b0;
            r_ovalid   <= 1'b0;
            r_clr_addr <= '0;
            r_clr_left <= (MEM_AW + 1)'(MEM_DEPTH);
        end else begin
            r_state <= n_state;
            // A new result item may replace one taken in the same cycle.
            if (r_state == ST_USE && last_probe && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_INIT, ST_WIPE: begin
                    r_clr_addr <= r_clr_addr + MEM_AW'(1);
                    r_clr_left <= r_clr_left - (MEM_AW + 1)'(1);
                end
                ST_ROT: begin
                    if (rot_now) begin
                        r_last     <= r_time;
                        r_act      <= ~r_act;
                        r_clr_addr <= r_act ? '0 : MEM_AW'(FILT_WORDS);
                        r_clr_left <= (MEM_AW + 1)'(FILT_WORDS);
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_mode <= s_axis_tuser[0];
                r_time <= s_axis_tdata[31:0];
                r_cnt  <= '0;
                r_rem  <= '0;
                if (s_axis_tuser[0] == MODE_INSERT) begin
                    r_w0 <= {s_axis_tdata[63:32], s_axis_tdata[95:64]};
                    r_w1 <= {16'd0, s_axis_tdata[111:96], 16'd0, s_axis_tdata[143:128]};
                end else begin
                    r_w0 <= {s_axis_tdata[95:64], s_axis_tdata[63:32]};
                    r_w1 <= {16'd0, s_axis_tdata[127:112], 16'd0, s_axis_tdata[143:128]};
                end
            end
            ST_DIV: begin
                r_rem <= rem_nx;
                r_cnt <= r_cnt + 5'd1;
            end
            ST_ROT: begin
                r_x    <= r_w0;
                r_mc   <= '0;
                r_ph   <= '0;
                r_pass <= 1'b0;
            end
            ST_HASH: begin
                r_acc <= full;
                r_mc  <= (r_mc == 2'd2) ? 2'd0 : r_mc + 2'd1;
                if (r_mc == 2'd2) begin
                    if (r_ph != 3'd6 || r_pass) begin
                        r_ph <= r_ph + 3'd1;
                    end
                    case (r_ph)
                        3'd0: r_x <= fin;
                        3'd1: begin
                            r_m0 <= full;
                            r_x  <= r_w1;
                        end
                        3'd2: r_x <= fin;
                        3'd3: begin
                            r_m1 <= full;
                            r_x  <= FIRST_SEED ^ MM_M16 ^ r_m0;
                        end
                        3'd4: r_x <= full ^ r_m1;
                        3'd5: r_x <= fin;
                        default: begin
                            // End of one hash: seed the second with the first.
                            if (!r_pass) begin
                                r_a    <= fin;
                                r_x    <= fin ^ MM_M16 ^ r_m0;
                                r_pass <= 1'b1;
                                r_ph   <= 3'd4;
                            end else begin
                                r_b   <= fin[ROW_W-1:0];
                                r_n   <= r_a[ROW_W-1:0];
                                r_row <= '0;
                                r_pf  <= 1'b0;
                                r_h0  <= 1'b1;
                                r_h1  <= 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_USE: begin
                if (r_pf) begin
                    r_h1 <= r_h1 & probe_bit;
                end else begin
                    r_h0 <= r_h0 & probe_bit;
                end
                // Step to the next row, or back to row zero of filter one.
                if (r_row == ROW_IW'(NUM_HASHES - 1)) begin
                    if (!last_probe) begin
                        r_row <= '0;
                        r_pf  <= 1'b1;
                        r_n   <= r_a[ROW_W-1:0];
                    end
                end else begin
                    r_row <= r_row + ROW_IW'(1);
                    r_n   <= r_n + r_b;
                end
                if (last_probe && (!r_ovalid || m_axis_tready)) begin
                    r_ohit <= (r_mode == MODE_QUERY)
                            && ((r_h0 && (r_pf || probe_bit))
                            || (r_h1 && probe_bit && r_pf));
                end
            end
            default: ;
        endcase
    end

endmodule
